[sv/sle_pkg.sv]
// Types, constants and codes shared by the sorted list engine.
`timescale 1ns / 1ps
package sle_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_DELETE = 2'd1;
    localparam logic [1:0] ACT_SEARCH = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

    typedef struct packed {
        logic [1:0]         action;
        logic signed [31:0] value;
    } t_in_item;

    typedef struct packed {
        logic [4:0] position;
        logic       found;
        logic [4:0] entry_count;
        logic [1:0] status;
    } t_out_item;

endpackage

[sv/sorted_list_engine.sv]
// Sorted list engine: scan, shift and count control around one entry memory.
// Sequence: a search, a full insert or a missed delete scans the entries, then strobes the result;
// an insert or a hit delete also moves the entries behind the position one at a time, each with a
// read and a write. One entry read per scan step and one comparator set the pace.
// Throughput: one transfer at a time; busy stays high until the result is registered.
// Reset: synchronous active low; clears the count and control, entry contents stay unknown.
`timescale 1ns / 1ps
module sorted_list_engine (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  sle_pkg::t_in_item  i_item,
    output logic               busy,
    output logic               o_valid,
    output sle_pkg::t_out_item o_result
);
    import sle_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_EXEC   = 3'd2;
    localparam logic [2:0] S_INS_RD = 3'd3;
    localparam logic [2:0] S_INS_WR = 3'd4;
    localparam logic [2:0] S_DEL_RD = 3'd5;
    localparam logic [2:0] S_DEL_WR = 3'd6;

    logic signed [31:0] r_mem [MAX_ENTRIES];
    logic signed [31:0] r_rd;

    logic [2:0]       r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [CNT_W-1:0] r_idx, n_idx;
    logic [CNT_W-1:0] r_k, n_k;
    logic             r_eq, n_eq;
    t_in_item         r_in, n_in;
    logic             r_valid, n_valid;
    t_out_item        r_res, n_res;

    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic signed [31:0] wr_data;
    logic               cmp_ge;

    assign cmp_ge = $signed(r_rd) >= $signed(r_in.value);

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_idx   = r_idx;
        n_k     = r_k;
        n_eq    = r_eq;
        n_in    = r_in;
        n_valid = 1'b0;
        n_res   = r_res;
        rd_en   = 1'b0;
        rd_addr = '0;
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = r_in.value;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_in  = i_item;
                    n_idx = '0;
                    n_eq  = 1'b0;
                    rd_en = 1'b1;
                    if (r_cnt == '0) begin
                        n_state = S_EXEC;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (cmp_ge) begin
                    n_eq    = (r_rd == r_in.value);
                    n_state = S_EXEC;
                end else if (CNT_W'(r_idx + 1'b1) == r_cnt) begin
                    n_idx   = r_cnt;
                    n_state = S_EXEC;
                end else begin
                    n_idx   = CNT_W'(r_idx + 1'b1);
                    rd_en   = 1'b1;
                    rd_addr = IDX_W'(r_idx + 1'b1);
                end
            end
            S_EXEC: begin
                n_res.found       = r_eq;
                n_res.entry_count = 5'(r_cnt);
                n_res.status      = ST_OK;
                n_res.position    = 5'(r_idx + 1'b1);
                case (r_in.action)
                    ACT_INSERT: begin
                        if (r_cnt == CNT_W'(MAX_ENTRIES)) begin
                            n_res.status = ST_FULL;
                            n_valid      = 1'b1;
                            n_state      = S_IDLE;
                        end else begin
                            n_k     = r_cnt;
                            n_state = S_INS_RD;
                        end
                    end
                    ACT_DELETE: begin
                        if (r_eq) begin
                            n_k     = r_idx;
                            n_state = S_DEL_RD;
                        end else begin
                            n_res.position = 5'(r_cnt + 1'b1);
                            n_res.status   = ST_NOT_FOUND;
                            n_valid        = 1'b1;
                            n_state        = S_IDLE;
                        end
                    end
                    default: begin
                        if (!r_eq) begin
                            n_res.position = 5'(r_cnt + 1'b1);
                            n_res.status   = ST_NOT_FOUND;
                        end
                        n_valid = 1'b1;
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_INS_RD: begin
                if (r_k > r_idx) begin
                    rd_en   = 1'b1;
                    rd_addr = IDX_W'(r_k - 1'b1);
                    n_state = S_INS_WR;
                end else begin
                    wr_en             = 1'b1;
                    wr_addr           = IDX_W'(r_idx);
                    wr_data           = r_in.value;
                    n_cnt             = CNT_W'(r_cnt + 1'b1);
                    n_res.entry_count = 5'(r_cnt + 1'b1);
                    n_valid           = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            S_INS_WR: begin
                wr_en   = 1'b1;
                wr_addr = IDX_W'(r_k);
                wr_data = r_rd;
                n_k     = CNT_W'(r_k - 1'b1);
                n_state = S_INS_RD;
            end
            S_DEL_RD: begin
                if (CNT_W'(r_k + 1'b1) < r_cnt) begin
                    rd_en   = 1'b1;
                    rd_addr = IDX_W'(r_k + 1'b1);
                    n_state = S_DEL_WR;
                end else begin
                    n_cnt             = CNT_W'(r_cnt - 1'b1);
                    n_res.entry_count = 5'(r_cnt - 1'b1);
                    n_valid           = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            S_DEL_WR: begin
                wr_en   = 1'b1;
                wr_addr = IDX_W'(r_k);
                wr_data = r_rd;
                n_k     = CNT_W'(r_k + 1'b1);
                n_state = S_DEL_RD;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        r_k   <= n_k;
        r_eq  <= n_eq;
        r_in  <= n_in;
        r_res <= n_res;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_valid  = r_valid;
    assign o_result = r_res;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(MAX_ENTRIES))
        else $error("entry count above capacity");

    a_cnt_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (n_cnt != r_cnt) |-> n_valid)
        else $error("count changed outside a finishing step");

    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_idx < r_cnt))
        else $error("scan index beyond count");

    a_full_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.status == ST_FULL) |-> (r_cnt == CNT_W'(MAX_ENTRIES)))
        else $error("full reported below capacity");

    a_notfound_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.status == ST_NOT_FOUND)
            |-> (!o_result.found && o_result.position == 5'(o_result.entry_count + 1'b1)))
        else $error("not-found result with bad position");

    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while busy");

endmodule
